// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define JSV_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define JSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jsv_pkg.sv =====
// Types, codes and constants shared by the JSON stream validator.
package jsv_pkg;

    localparam int MAX_NESTING_DEF = 32;

    // Lexer modes
    typedef enum logic [4:0] {
        M_VALUE     = 5'd0,
        M_ARR_FIRST = 5'd1,
        M_OBJ_FIRST = 5'd2,
        M_KEY       = 5'd3,
        M_COLON     = 5'd4,
        M_AFTER     = 5'd5,
        M_N_SIGN    = 5'd6,
        M_N_ZERO    = 5'd7,
        M_N_INT     = 5'd8,
        M_N_DOT     = 5'd9,
        M_N_FRAC    = 5'd10,
        M_N_EXP     = 5'd11,
        M_N_EXPSIGN = 5'd12,
        M_N_EXPDIG  = 5'd13,
        M_LIT_TRUE  = 5'd14,
        M_LIT_FALSE = 5'd15,
        M_LIT_NULL  = 5'd16,
        M_STR_VAL   = 5'd17,
        M_STR_KEY   = 5'd18,
        M_ESC_VAL   = 5'd19,
        M_ESC_KEY   = 5'd20,
        M_HEX_VAL   = 5'd21,
        M_HEX_KEY   = 5'd22
    } lex_mode_t;

    // Error kinds
    localparam logic [1:0] FAIL_NONE   = 2'd0;
    localparam logic [1:0] FAIL_SYNTAX = 2'd1;
    localparam logic [1:0] FAIL_DEPTH  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_1        = 8'h31;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_E     = 8'h45;
    localparam logic [7:0] CH_UP_F     = 8'h46;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_beat_t;

    // Result beat
    typedef struct packed {
        logic       valid_res;
        logic [1:0] error_kind;
    } result_beat_t;

    // Stack command from the lexer
    typedef struct packed {
        logic push;
        logic is_obj;
    } stack_op_t;

endpackage

// ===== hw/rtl/jsv_stack.sv =====
// Container stack: one bit per open level, top entry kept in a register.
module jsv_stack
    import jsv_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic                               clk,
    input  stack_op_t                          op,
    input  logic [$clog2(MAX_NESTING + 1)-1:0] level_next,
    output logic                               top_obj
);

    localparam int LW = $clog2(MAX_NESTING + 1);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    logic          mem [0:MAX_NESTING-1];
    logic [AW-1:0] addr;
    logic          top_reg;

    // Entry at the new top of stack: the pushed slot, or the one below after a pop
    assign addr = AW'(level_next - LW'(1));

    // Write on push, read the new top with bypass of a same-cycle push
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[addr] <= op.is_obj;
        end
        top_reg <= op.push ? op.is_obj : mem[addr];
    end

    assign top_obj = top_reg;

endmodule

// ===== hw/rtl/json_stream_validator.sv =====
// Streaming JSON syntax validator: one document byte per beat, one verdict per document.
// Throughput: one byte per cycle; a last byte is held only while the previous verdict stalls.
// The verdict is registered: it appears in the cycle after the beat that carries the last byte.
// The stack top comes from a registered memory read with push bypass, set up the cycle before.
// Reset (async, active low) clears lexer mode, level, counters and the result valid flag.
// The stack memory is not cleared; only pushed entries are ever used.
module json_stream_validator
    import jsv_pkg::*;
#(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_beat_t   byte_data,
    output logic         res_valid,
    input  logic         res_stall,
    output result_beat_t res_data
);

`include "assert_macros.svh"

    localparam int LW = $clog2(MAX_NESTING + 1);

    lex_mode_t    mode_reg, mode_next;
    logic [LW-1:0] level_reg, level_next;
    logic [2:0]   count_reg, count_next;
    logic [1:0]   fail_reg, fail_next;
    logic         zero_reg, zero_next;
    logic         res_valid_reg, res_valid_next;
    result_beat_t res_data_reg, res_next;

    stack_op_t    stk_op;
    logic         top_obj;
    logic         byte_acc;
    logic [7:0]   c;
    logic         is_space, is_digit, is_hex, in_string;

    // begin-value outcome
    lex_mode_t    bv_mode;
    logic [2:0]   bv_count;
    logic [1:0]   bv_fail;
    logic         bv_push, bv_obj;

    // after-value outcome
    lex_mode_t    af_mode;
    logic [1:0]   af_fail;
    logic         af_pop;

    // literal lookup
    logic [7:0]   lit_ch;
    logic [2:0]   lit_len;

    // checker terms
    logic         last_acc, doc_idle, failed, verdict_ok;

    // Document may end in this mode at this level
    function automatic logic doc_complete(lex_mode_t m, logic at_top);
        return at_top && (m == M_AFTER || m == M_N_ZERO || m == M_N_INT ||
                          m == M_N_FRAC || m == M_N_EXPDIG);
    endfunction

    jsv_stack #(
        .MAX_NESTING(MAX_NESTING)
    ) u_stack (
        .clk        (clk),
        .op         (stk_op),
        .level_next (level_next),
        .top_obj    (top_obj)
    );

    // Hold a last byte only while the previous verdict is still stalled
    assign byte_stall = res_valid_reg && res_stall && byte_data.last_byte;
    assign byte_acc   = byte_valid && !byte_stall;

    // Classify the byte
    assign c         = byte_data.data_byte;
    assign is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign is_digit  = (c >= CH_0) && (c <= CH_9);
    assign is_hex    = is_digit || ((c >= CH_A) && (c <= CH_F)) ||
                       ((c >= CH_UP_A) && (c <= CH_UP_F));
    assign in_string = mode_reg >= M_STR_VAL;

    // Expected next letter of the literal in progress
    always_comb
    begin
        lit_ch  = CH_NUL;
        lit_len = 3'd4;
        case (mode_reg)
            M_LIT_TRUE:
            begin
                case (count_reg)
                    3'd1:    lit_ch = CH_R;
                    3'd2:    lit_ch = CH_U;
                    3'd3:    lit_ch = CH_E;
                    default: lit_ch = CH_NUL;
                endcase
            end
            M_LIT_FALSE:
            begin
                lit_len = 3'd5;
                case (count_reg)
                    3'd1:    lit_ch = CH_A;
                    3'd2:    lit_ch = CH_L;
                    3'd3:    lit_ch = CH_S;
                    3'd4:    lit_ch = CH_E;
                    default: lit_ch = CH_NUL;
                endcase
            end
            M_LIT_NULL:
            begin
                case (count_reg)
                    3'd1:    lit_ch = CH_U;
                    3'd2:    lit_ch = CH_L;
                    3'd3:    lit_ch = CH_L;
                    default: lit_ch = CH_NUL;
                endcase
            end
            default: lit_ch = CH_NUL;
        endcase
    end

    // Start of a value
    always_comb
    begin
        bv_mode  = mode_reg;
        bv_count = count_reg;
        bv_fail  = FAIL_NONE;
        bv_push  = 1'b0;
        bv_obj   = 1'b0;
        case (c)
            CH_QUOTE: bv_mode = M_STR_VAL;
            CH_LBRACE, CH_LBRACKET:
            begin
                if (level_reg >= LW'(MAX_NESTING))
                begin
                    bv_fail = FAIL_DEPTH;
                end
                else
                begin
                    bv_push = 1'b1;
                    bv_obj  = (c == CH_LBRACE);
                    bv_mode = (c == CH_LBRACE) ? M_OBJ_FIRST : M_ARR_FIRST;
                end
            end
            CH_T:
            begin
                bv_mode  = M_LIT_TRUE;
                bv_count = 3'd1;
            end
            CH_F:
            begin
                bv_mode  = M_LIT_FALSE;
                bv_count = 3'd1;
            end
            CH_N:
            begin
                bv_mode  = M_LIT_NULL;
                bv_count = 3'd1;
            end
            CH_MINUS: bv_mode = M_N_SIGN;
            CH_0:     bv_mode = M_N_ZERO;
            default:
            begin
                if ((c >= CH_1) && (c <= CH_9))
                begin
                    bv_mode = M_N_INT;
                end
                else
                begin
                    bv_fail = FAIL_SYNTAX;
                end
            end
        endcase
    end

    // After a value: separator or closing bracket of the open container
    always_comb
    begin
        af_mode = M_AFTER;
        af_fail = FAIL_NONE;
        af_pop  = 1'b0;
        if (level_reg == '0)
        begin
            af_fail = FAIL_SYNTAX;
        end
        else if (c == CH_COMMA)
        begin
            af_mode = top_obj ? M_KEY : M_VALUE;
        end
        else if (c == (top_obj ? CH_RBRACE : CH_RBRACKET))
        begin
            af_pop = 1'b1;
        end
        else
        begin
            af_fail = FAIL_SYNTAX;
        end
    end

    // Next state of the lexer and the verdict
    always_comb
    begin
        logic rehandle;
        mode_next  = mode_reg;
        level_next = level_reg;
        count_next = count_reg;
        fail_next  = fail_reg;
        zero_next  = zero_reg;
        stk_op     = '{push: 1'b0, is_obj: 1'b0};
        res_next   = res_data_reg;
        rehandle   = 1'b0;
        if (byte_acc)
        begin
            if (!zero_reg)
            begin
                if (c == CH_NUL)
                begin
                    if (fail_reg == FAIL_NONE && !doc_complete(mode_reg, level_reg == '0))
                    begin
                        fail_next = FAIL_SYNTAX;
                    end
                    zero_next = 1'b1;
                end
                else if (fail_reg == FAIL_NONE && (in_string || !is_space))
                begin
                    case (mode_reg)
                        M_VALUE:
                        begin
                            mode_next  = bv_mode;
                            count_next = bv_count;
                            fail_next  = bv_fail;
                        end
                        M_ARR_FIRST:
                        begin
                            if (c == CH_RBRACKET)
                            begin
                                level_next = level_reg - LW'(1);
                                mode_next  = M_AFTER;
                            end
                            else
                            begin
                                mode_next  = bv_mode;
                                count_next = bv_count;
                                fail_next  = bv_fail;
                            end
                        end
                        M_OBJ_FIRST:
                        begin
                            if (c == CH_RBRACE)
                            begin
                                level_next = level_reg - LW'(1);
                                mode_next  = M_AFTER;
                            end
                            else if (c == CH_QUOTE)
                            begin
                                mode_next = M_STR_KEY;
                            end
                            else
                            begin
                                fail_next = FAIL_SYNTAX;
                            end
                        end
                        M_KEY:
                        begin
                            if (c == CH_QUOTE) mode_next = M_STR_KEY;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_COLON:
                        begin
                            if (c == CH_COLON) mode_next = M_VALUE;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_AFTER: rehandle = 1'b1;
                        M_N_SIGN:
                        begin
                            if (c == CH_0) mode_next = M_N_ZERO;
                            else if ((c >= CH_1) && (c <= CH_9)) mode_next = M_N_INT;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_N_ZERO, M_N_INT:
                        begin
                            if (mode_reg == M_N_INT && is_digit) mode_next = M_N_INT;
                            else if (c == CH_DOT) mode_next = M_N_DOT;
                            else if (c == CH_E || c == CH_UP_E) mode_next = M_N_EXP;
                            else rehandle = 1'b1;
                        end
                        M_N_DOT:
                        begin
                            if (is_digit) mode_next = M_N_FRAC;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_N_FRAC:
                        begin
                            if (is_digit) mode_next = M_N_FRAC;
                            else if (c == CH_E || c == CH_UP_E) mode_next = M_N_EXP;
                            else rehandle = 1'b1;
                        end
                        M_N_EXP:
                        begin
                            if (c == CH_PLUS || c == CH_MINUS) mode_next = M_N_EXPSIGN;
                            else if (is_digit) mode_next = M_N_EXPDIG;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_N_EXPSIGN:
                        begin
                            if (is_digit) mode_next = M_N_EXPDIG;
                            else fail_next = FAIL_SYNTAX;
                        end
                        M_N_EXPDIG:
                        begin
                            if (!is_digit) rehandle = 1'b1;
                        end
                        M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL:
                        begin
                            if (count_reg >= lit_len || c != lit_ch)
                            begin
                                fail_next = FAIL_SYNTAX;
                            end
                            else if (count_reg + 3'd1 == lit_len)
                            begin
                                count_next = 3'd0;
                                mode_next  = M_AFTER;
                            end
                            else
                            begin
                                count_next = count_reg + 3'd1;
                            end
                        end
                        M_STR_VAL, M_STR_KEY:
                        begin
                            if (c == CH_QUOTE)
                            begin
                                mode_next = (mode_reg == M_STR_KEY) ? M_COLON : M_AFTER;
                            end
                            else if (c < CH_SPACE)
                            begin
                                fail_next = FAIL_SYNTAX;
                            end
                            else if (c == CH_BSLASH)
                            begin
                                mode_next = (mode_reg == M_STR_KEY) ? M_ESC_KEY : M_ESC_VAL;
                            end
                        end
                        M_ESC_VAL, M_ESC_KEY:
                        begin
                            if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH ||
                                c == CH_B || c == CH_F || c == CH_N || c == CH_R ||
                                c == CH_T)
                            begin
                                mode_next = (mode_reg == M_ESC_KEY) ? M_STR_KEY : M_STR_VAL;
                            end
                            else if (c == CH_U)
                            begin
                                mode_next  = (mode_reg == M_ESC_KEY) ? M_HEX_KEY : M_HEX_VAL;
                                count_next = 3'd0;
                            end
                            else
                            begin
                                fail_next = FAIL_SYNTAX;
                            end
                        end
                        M_HEX_VAL, M_HEX_KEY:
                        begin
                            if (!is_hex)
                            begin
                                fail_next = FAIL_SYNTAX;
                            end
                            else if (count_reg >= 3'd3)
                            begin
                                count_next = 3'd0;
                                mode_next  = (mode_reg == M_HEX_KEY) ? M_STR_KEY : M_STR_VAL;
                            end
                            else
                            begin
                                count_next = count_reg + 3'd1;
                            end
                        end
                        default: fail_next = FAIL_SYNTAX;
                    endcase

                    // Push for an opened container
                    if ((mode_reg == M_VALUE || (mode_reg == M_ARR_FIRST && c != CH_RBRACKET))
                        && bv_push)
                    begin
                        stk_op     = '{push: 1'b1, is_obj: bv_obj};
                        level_next = level_reg + LW'(1);
                    end

                    // A byte that ends a number, or follows a value, is taken as a separator
                    if (rehandle)
                    begin
                        mode_next = af_mode;
                        fail_next = af_fail;
                        if (af_pop)
                        begin
                            level_next = level_reg - LW'(1);
                        end
                    end
                end
            end

            // Last byte: form the verdict and start a new document
            if (byte_data.last_byte)
            begin
                res_next.error_kind = fail_next;
                if (!zero_next && fail_next == FAIL_NONE &&
                    !doc_complete(mode_next, level_next == '0))
                begin
                    res_next.error_kind = FAIL_SYNTAX;
                end
                res_next.valid_res = (res_next.error_kind == FAIL_NONE);
                mode_next  = M_VALUE;
                level_next = '0;
                count_next = 3'd0;
                fail_next  = FAIL_NONE;
                zero_next  = 1'b0;
            end
        end
    end

    // Result valid: set by a last byte, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (byte_acc && byte_data.last_byte)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_VALUE;
            level_reg     <= '0;
            count_reg     <= 3'd0;
            fail_reg      <= FAIL_NONE;
            zero_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            count_reg     <= count_next;
            fail_reg      <= fail_next;
            zero_reg      <= zero_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Terms for the checks below
    assign last_acc   = byte_acc && byte_data.last_byte;
    assign doc_idle   = level_reg == '0 && mode_reg == M_VALUE && fail_reg == FAIL_NONE;
    assign failed     = fail_reg != FAIL_NONE;
    assign verdict_ok = res_data_reg.valid_res == (res_data_reg.error_kind == FAIL_NONE) &&
                        res_data_reg.error_kind <= FAIL_DEPTH;

    `JSV_ASSERT(a_level_bound, level_reg <= LW'(MAX_NESTING), "stack level beyond MAX_NESTING")
    `JSV_ASSERT_NEXT(a_last_resets, last_acc, res_valid_reg && doc_idle, "no verdict or restart")
    `JSV_ASSERT(a_verdict_code, !res_valid_reg || verdict_ok, "verdict flag and error kind disagree")
    `JSV_ASSERT_NEXT(a_fail_sticky, failed && !last_acc, fail_reg == $past(fail_reg), "error lost")

endmodule

// ===== test/tb_json_stream_validator.sv =====
// Self-checking testbench for the streaming JSON syntax validator.
`timescale 1ns / 1ps

module tb_json_stream_validator;
    import jsv_pkg::*;

    localparam int MAX_NEST    = MAX_NESTING_DEF;
    localparam int SW          = $clog2(MAX_NEST);
    localparam int RAND_BEATS  = 1260;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_stall;
    byte_beat_t   byte_data  = '0;
    logic         res_valid;
    logic         res_stall  = 1'b0;
    result_beat_t res_data;

    json_stream_validator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always #6 clk = ~clk;

    // Parser state mirrored from the block
    lex_mode_t  parse_mode;
    bit         parse_stack [MAX_NEST];
    logic [5:0] parse_level;
    logic [2:0] parse_tok;
    logic [1:0] parse_fail;
    bit         parse_nul;

    byte_beat_t   pending_beats [$];
    result_beat_t verdicts_due [$];
    logic [7:0]   doc_text [$];
    int           total_beats = 0;
    int           beats_taken = 0;
    int           bad_verdicts = 0;
    int           cycle_count = 0;
    int           calm_left [2];
    int           feed_wait = 0;
    int           drain_wait = 0;
    int           next_wait;
    result_beat_t due_verdict;
    bit           wrong;

    // ---------------------------------------------------------------- parser

    function automatic void reset_parser();
        parse_mode  = M_VALUE;
        parse_level = '0;
        parse_tok   = '0;
        parse_fail  = FAIL_NONE;
        parse_nul   = 1'b0;
    endfunction

    function automatic void flag_error(logic [1:0] kind);
        if (parse_fail == FAIL_NONE)
            parse_fail = kind;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void open_nest(bit obj);
        if (parse_level >= 6'(MAX_NEST))
        begin
            flag_error(FAIL_DEPTH);
            return;
        end
        parse_stack[SW'(parse_level)] = obj;
        parse_level = parse_level + 6'd1;
        parse_mode = obj ? M_OBJ_FIRST : M_ARR_FIRST;
    endfunction

    function automatic void start_value(logic [7:0] c);
        if (c == CH_QUOTE)
            parse_mode = M_STR_VAL;
        else if (c == CH_LBRACE)
            open_nest(1'b1);
        else if (c == CH_LBRACKET)
            open_nest(1'b0);
        else if (c == CH_T)
        begin
            parse_mode = M_LIT_TRUE;
            parse_tok = 3'd1;
        end
        else if (c == CH_F)
        begin
            parse_mode = M_LIT_FALSE;
            parse_tok = 3'd1;
        end
        else if (c == CH_N)
        begin
            parse_mode = M_LIT_NULL;
            parse_tok = 3'd1;
        end
        else if (c == CH_MINUS)
            parse_mode = M_N_SIGN;
        else if (c == CH_0)
            parse_mode = M_N_ZERO;
        else if (c >= CH_1 && c <= CH_9)
            parse_mode = M_N_INT;
        else
            flag_error(FAIL_SYNTAX);
    endfunction

    // Match the next letter of true, false or null
    function automatic void literal_step(logic [7:0] c);
        logic [7:0] want;
        logic [2:0] len;
        len = (parse_mode == M_LIT_FALSE) ? 3'd5 : 3'd4;
        want = CH_NUL;
        case (parse_mode)
            M_LIT_TRUE:
                case (parse_tok)
                    3'd0: want = CH_T;
                    3'd1: want = CH_R;
                    3'd2: want = CH_U;
                    3'd3: want = CH_E;
                    default: want = CH_NUL;
                endcase
            M_LIT_FALSE:
                case (parse_tok)
                    3'd0: want = CH_F;
                    3'd1: want = CH_A;
                    3'd2: want = CH_L;
                    3'd3: want = CH_S;
                    3'd4: want = CH_E;
                    default: want = CH_NUL;
                endcase
            default:
                case (parse_tok)
                    3'd0: want = CH_N;
                    3'd1: want = CH_U;
                    3'd2: want = CH_L;
                    3'd3: want = CH_L;
                    default: want = CH_NUL;
                endcase
        endcase
        if (parse_tok >= len || want != c)
        begin
            flag_error(FAIL_SYNTAX);
            return;
        end
        parse_tok = parse_tok + 3'd1;
        if (parse_tok == len)
        begin
            parse_tok = '0;
            parse_mode = M_AFTER;
        end
    endfunction

    // Advance on one kept byte; return 0 when a number ends and the byte must be redone
    function automatic bit parse_char(logic [7:0] c);
        bit key;
        bit top;
        key = (parse_mode == M_STR_KEY) || (parse_mode == M_ESC_KEY) ||
              (parse_mode == M_HEX_KEY);
        case (parse_mode)
            M_VALUE: start_value(c);
            M_ARR_FIRST:
                if (c == CH_RBRACKET)
                begin
                    parse_level = parse_level - 6'd1;
                    parse_mode = M_AFTER;
                end
                else
                    start_value(c);
            M_OBJ_FIRST:
                if (c == CH_RBRACE)
                begin
                    parse_level = parse_level - 6'd1;
                    parse_mode = M_AFTER;
                end
                else if (c == CH_QUOTE)
                    parse_mode = M_STR_KEY;
                else
                    flag_error(FAIL_SYNTAX);
            M_KEY:
                if (c == CH_QUOTE)
                    parse_mode = M_STR_KEY;
                else
                    flag_error(FAIL_SYNTAX);
            M_COLON:
                if (c == CH_COLON)
                    parse_mode = M_VALUE;
                else
                    flag_error(FAIL_SYNTAX);
            M_AFTER:
                if (parse_level == 0)
                    flag_error(FAIL_SYNTAX);
                else
                begin
                    top = parse_stack[SW'(parse_level - 6'd1)];
                    if (c == CH_COMMA)
                        parse_mode = top ? M_KEY : M_VALUE;
                    else if (c == (top ? CH_RBRACE : CH_RBRACKET))
                        parse_level = parse_level - 6'd1;
                    else
                        flag_error(FAIL_SYNTAX);
                end
            M_N_SIGN:
                if (c == CH_0)
                    parse_mode = M_N_ZERO;
                else if (c >= CH_1 && c <= CH_9)
                    parse_mode = M_N_INT;
                else
                    flag_error(FAIL_SYNTAX);
            M_N_ZERO, M_N_INT:
            begin
                if (parse_mode == M_N_INT && is_digit(c))
                    return 1'b1;
                if (c == CH_DOT)
                begin
                    parse_mode = M_N_DOT;
                    return 1'b1;
                end
                if (c == CH_E || c == CH_UP_E)
                begin
                    parse_mode = M_N_EXP;
                    return 1'b1;
                end
                parse_mode = M_AFTER;
                return 1'b0;
            end
            M_N_DOT:
                if (is_digit(c))
                    parse_mode = M_N_FRAC;
                else
                    flag_error(FAIL_SYNTAX);
            M_N_FRAC:
            begin
                if (is_digit(c))
                    return 1'b1;
                if (c == CH_E || c == CH_UP_E)
                begin
                    parse_mode = M_N_EXP;
                    return 1'b1;
                end
                parse_mode = M_AFTER;
                return 1'b0;
            end
            M_N_EXP:
                if (c == CH_PLUS || c == CH_MINUS)
                    parse_mode = M_N_EXPSIGN;
                else if (is_digit(c))
                    parse_mode = M_N_EXPDIG;
                else
                    flag_error(FAIL_SYNTAX);
            M_N_EXPSIGN:
                if (is_digit(c))
                    parse_mode = M_N_EXPDIG;
                else
                    flag_error(FAIL_SYNTAX);
            M_N_EXPDIG:
            begin
                if (is_digit(c))
                    return 1'b1;
                parse_mode = M_AFTER;
                return 1'b0;
            end
            M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: literal_step(c);
            M_STR_VAL, M_STR_KEY:
                if (c == CH_QUOTE)
                    parse_mode = key ? M_COLON : M_AFTER;
                else if (c < CH_SPACE)
                    flag_error(FAIL_SYNTAX);
                else if (c == CH_BSLASH)
                    parse_mode = key ? M_ESC_KEY : M_ESC_VAL;
            M_ESC_VAL, M_ESC_KEY:
                if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
                    c == CH_F || c == CH_N || c == CH_R || c == CH_T)
                    parse_mode = key ? M_STR_KEY : M_STR_VAL;
                else if (c == CH_U)
                begin
                    parse_mode = key ? M_HEX_KEY : M_HEX_VAL;
                    parse_tok = '0;
                end
                else
                    flag_error(FAIL_SYNTAX);
            M_HEX_VAL, M_HEX_KEY:
                if (!(is_digit(c) || (c >= CH_A && c <= CH_F) ||
                      (c >= CH_UP_A && c <= CH_UP_F)))
                    flag_error(FAIL_SYNTAX);
                else
                begin
                    parse_tok = parse_tok + 3'd1;
                    if (parse_tok >= 3'd4)
                    begin
                        parse_tok = '0;
                        parse_mode = key ? M_STR_KEY : M_STR_VAL;
                    end
                end
            default: flag_error(FAIL_SYNTAX);
        endcase
        return 1'b1;
    endfunction

    // End of document: only a closed value counts
    function automatic void close_doc();
        if (!(parse_level == 0 &&
              (parse_mode == M_AFTER || parse_mode == M_N_ZERO || parse_mode == M_N_INT ||
               parse_mode == M_N_FRAC || parse_mode == M_N_EXPDIG)))
            flag_error(FAIL_SYNTAX);
    endfunction

    // Step the parser on one accepted beat and queue the verdict it causes
    function automatic void feed_parser(byte_beat_t b);
        result_beat_t v;
        bit           blank;
        if (!parse_nul)
        begin
            if (b.data_byte == CH_NUL)
            begin
                close_doc();
                parse_nul = 1'b1;
            end
            else if (parse_fail == FAIL_NONE)
            begin
                blank = b.data_byte == CH_SPACE || b.data_byte == CH_TAB ||
                        b.data_byte == CH_LF || b.data_byte == CH_CR;
                if (parse_mode >= M_STR_VAL || !blank)
                begin
                    if (!parse_char(b.data_byte) && parse_fail == FAIL_NONE)
                        void'(parse_char(b.data_byte));
                end
            end
        end
        if (b.last_byte)
        begin
            if (!parse_nul)
                close_doc();
            v.valid_res  = (parse_fail == FAIL_NONE);
            v.error_kind = parse_fail;
            verdicts_due.push_back(v);
            reset_parser();
        end
    endfunction

    // ------------------------------------------------------------- documents

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // Append a byte outside strings, sometimes followed by whitespace
    function automatic void put(logic [7:0] c);
        doc_text.push_back(c);
        if ($urandom_range(0, 7) == 0)
            doc_text.push_back(pick_blank());
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_text.push_back(s[i]);
    endfunction

    function automatic void gen_string();
        logic [7:0] c;
        int         r;
        doc_text.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    c = 8'($urandom_range(32, 126));
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        c = CH_S;
                    doc_text.push_back(c);
                end
                4: doc_text.push_back(8'($urandom_range(128, 255)));
                5, 6:
                begin
                    doc_text.push_back(CH_BSLASH);
                    case ($urandom_range(0, 7))
                        0: doc_text.push_back(CH_QUOTE);
                        1: doc_text.push_back(CH_BSLASH);
                        2: doc_text.push_back(CH_SLASH);
                        3: doc_text.push_back(CH_B);
                        4: doc_text.push_back(CH_F);
                        5: doc_text.push_back(CH_N);
                        6: doc_text.push_back(CH_R);
                        default: doc_text.push_back(CH_T);
                    endcase
                end
                7, 8:
                begin
                    doc_text.push_back(CH_BSLASH);
                    doc_text.push_back(CH_U);
                    repeat (4)
                    begin
                        r = $urandom_range(0, 21);
                        if (r < 10)
                            doc_text.push_back(CH_0 + 8'(r));
                        else if (r < 16)
                            doc_text.push_back(CH_A + 8'(r - 10));
                        else
                            doc_text.push_back(CH_UP_A + 8'(r - 16));
                    end
                end
                default: doc_text.push_back(CH_SPACE);
            endcase
        end
        put(CH_QUOTE);
    endfunction

    function automatic void gen_key();
        gen_string();
        put(CH_COLON);
    endfunction

    function automatic void gen_leaf(int k);
        case (k)
            0, 4: gen_string();
            2:
                case ($urandom_range(0, 2))
                    0: begin put(CH_T); put(CH_R); put(CH_U); put(CH_E); end
                    1: begin put(CH_F); put(CH_A); put(CH_L); put(CH_S); put(CH_E); end
                    default: begin put(CH_N); put(CH_U); put(CH_L); put(CH_L); end
                endcase
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    put(CH_MINUS);
                if ($urandom_range(0, 3) == 0)
                    put(CH_0);
                else
                begin
                    put(CH_1 + 8'($urandom_range(0, 8)));
                    repeat ($urandom_range(0, 3))
                        put(pick_digit());
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    put(CH_DOT);
                    repeat ($urandom_range(1, 3))
                        put(pick_digit());
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    put($urandom_range(0, 1) ? CH_E : CH_UP_E);
                    case ($urandom_range(0, 2))
                        0: put(CH_PLUS);
                        1: put(CH_MINUS);
                        default: ;
                    endcase
                    repeat ($urandom_range(1, 2))
                        put(pick_digit());
                end
            end
        endcase
    endfunction

    // Build one well-formed value, nesting kept shallow, without recursion
    function automatic void gen_value_text();
        bit open_obj [$];
        int open_left [$];
        bit want;
        bit done;
        bit obj;
        int k;
        int n;
        want = 1'b1;
        done = 1'b0;
        while (!done)
        begin
            if (want)
            begin
                k = $urandom_range(0, open_obj.size() < 3 ? 7 : 4);
                if (k >= 5)
                begin
                    obj = (k == 7);
                    put(obj ? CH_LBRACE : CH_LBRACKET);
                    n = $urandom_range(0, 3);
                    if (n == 0)
                    begin
                        put(obj ? CH_RBRACE : CH_RBRACKET);
                        want = 1'b0;
                    end
                    else
                    begin
                        open_obj.push_back(obj);
                        open_left.push_back(n);
                        if (obj)
                            gen_key();
                    end
                end
                else
                begin
                    gen_leaf(k);
                    want = 1'b0;
                end
            end
            else if (open_obj.size() == 0)
                done = 1'b1;
            else if (open_left[$] > 1)
            begin
                open_left[$] = open_left[$] - 1;
                put(CH_COMMA);
                if (open_obj[$])
                    gen_key();
                want = 1'b1;
            end
            else
            begin
                put(open_obj[$] ? CH_RBRACE : CH_RBRACKET);
                void'(open_obj.pop_back());
                void'(open_left.pop_back());
            end
        end
    endfunction

    // Nest arrays and objects n deep around an optional leaf
    function automatic void gen_deep(int n, bit mixed);
        bit kinds [$];
        bit obj;
        for (int i = 0; i < n; i++)
        begin
            obj = mixed ? bit'($urandom_range(0, 1)) : 1'b0;
            kinds.push_back(obj);
            put(obj ? CH_LBRACE : CH_LBRACKET);
            if (obj)
                gen_key();
        end
        if (kinds[$] || $urandom_range(0, 1) == 0)
            gen_leaf($urandom_range(0, 4));
        while (kinds.size() != 0)
            put(kinds.pop_back() ? CH_RBRACE : CH_RBRACKET);
    endfunction

    // Move the document text into the beat queue, marking its final byte
    function automatic void emit_text();
        byte_beat_t b;
        if (doc_text.size() == 0)
            doc_text.push_back(CH_SPACE);
        for (int i = 0; i < doc_text.size(); i++)
        begin
            b.data_byte = doc_text[i];
            b.last_byte = (i == doc_text.size() - 1);
            pending_beats.push_back(b);
            total_beats++;
        end
        doc_text.delete();
    endfunction

    // Cycles to idle before the next beat; side 0 feeds bytes, side 1 drains verdicts
    function automatic int pick_wait(int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------- driver, monitor

    // Feed byte beats; hold a stalled beat, step the parser on each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                feed_parser(byte_data);
                beats_taken++;
            end
            if (!(byte_valid && byte_stall))
            begin
                if (feed_wait > 0)
                begin
                    feed_wait--;
                    byte_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    byte_data  <= pending_beats.pop_front();
                    byte_valid <= 1'b1;
                    feed_wait = pick_wait(0);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Check each verdict beat against the oldest expected one; stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_wait = 0;
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    bad_verdicts++;
                    if (bad_verdicts <= 10)
                        $display("unexpected verdict: valid_res %0b error_kind %0d",
                                 res_data.valid_res, res_data.error_kind);
                end
                else
                begin
                    due_verdict = verdicts_due.pop_front();
                    wrong = 1'b0;
                    if (res_data.valid_res !== due_verdict.valid_res)
                        wrong = 1'b1;
                    if (res_data.error_kind !== due_verdict.error_kind)
                        wrong = 1'b1;
                    if (wrong)
                    begin
                        bad_verdicts++;
                        if (bad_verdicts <= 10)
                            $display("verdict mismatch: valid_res exp %0b got %0b, %s %0d got %0d",
                                     due_verdict.valid_res, res_data.valid_res,
                                     "error_kind exp", due_verdict.error_kind,
                                     res_data.error_kind);
                    end
                end
                next_wait = pick_wait(1);
            end
            else if (res_valid && drain_wait > 0)
                next_wait = drain_wait - 1;
            else
                next_wait = drain_wait;
            drain_wait = next_wait;
            res_stall <= (next_wait != 0);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------- stimulus

    initial
    begin
        int directed_beats;
        int idx;
        int k;
        reset_parser();
        calm_left[0] = 0;
        calm_left[1] = 0;

        // Directed documents: literals, numbers, strings, containers, and malformed ones
        put_text("true");                              emit_text();
        put_text("false");                             emit_text();
        put_text("null");                              emit_text();
        put_text("{\"k\":[1,-0.5e+3,2E-7,0]}");        emit_text();
        put_text("[{},[],{\"a\":{}}]");                emit_text();
        put_text("\"a\\\" b\\u0fA9\\n\\/\"");          emit_text();
        put_text("tr ue");                             emit_text();
        put_text("1 2");                               emit_text();
        put_text("01");                                emit_text();
        // Control byte and high bytes inside a string
        put_text("\"a\tb\"");                          emit_text();
        doc_text.push_back(CH_QUOTE);
        doc_text.push_back(8'hFF);
        doc_text.push_back(8'h80);
        doc_text.push_back(CH_QUOTE);                  emit_text();
        // Zero byte ends the document; zero inside a string leaves it open
        put_text("[1]");
        doc_text.push_back(CH_NUL);
        put_text("x]");                                emit_text();
        put_text("\"ab");
        doc_text.push_back(CH_NUL);
        doc_text.push_back(CH_QUOTE);                  emit_text();
        // Bytes after the first error are dropped
        put_text("[1,]]]}");                           emit_text();
        // Empty, blank and one-byte invalid documents
        doc_text.push_back(CH_NUL);                    emit_text();
        put_text(" \t\r\n");                           emit_text();
        doc_text.push_back(8'hFF);                     emit_text();
        // Full stack, one level too deep, and too deep after a syntax error
        gen_deep(MAX_NEST, 1'b0);                      emit_text();
        gen_deep(MAX_NEST + 1, 1'b1);                  emit_text();
        put_text("x");
        repeat (MAX_NEST + 1)
            doc_text.push_back(CH_LBRACKET);           emit_text();
        // Incomplete tokens and bad structure
        put_text("-");                                 emit_text();
        put_text("1.");                                emit_text();
        put_text("1e+");                               emit_text();
        put_text("\"\\u12");                           emit_text();
        put_text("\"\\q\"");                           emit_text();
        put_text("{\"a\" 1}");                         emit_text();
        directed_beats = total_beats;

        // Random documents: mostly well formed, some spoiled, some noise
        while (total_beats < directed_beats + RAND_BEATS)
        begin
            k = $urandom_range(0, 99);
            if (k < 4)
                gen_deep($urandom_range(MAX_NEST - 3, MAX_NEST + 3), 1'b1);
            else if (k < 12)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    case ($urandom_range(0, 7))
                        0: doc_text.push_back(CH_LBRACE);
                        1: doc_text.push_back(CH_RBRACKET);
                        2: doc_text.push_back(CH_QUOTE);
                        3: doc_text.push_back(CH_COLON);
                        4: doc_text.push_back(pick_digit());
                        default: doc_text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    doc_text.push_back(pick_blank());
                gen_value_text();
            end

            // Spoil some documents: overwrite, insert, drop, cut short, zero byte
            if (k >= 72)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    if (doc_text.size() == 0)
                        doc_text.push_back(CH_SPACE);
                    idx = $urandom_range(0, doc_text.size() - 1);
                    case ($urandom_range(0, 5))
                        0: doc_text[idx] = 8'($urandom_range(0, 255));
                        1: doc_text.insert(idx, 8'($urandom_range(0, 255)));
                        2: if (doc_text.size() > 1) doc_text.delete(idx);
                        3: while (doc_text.size() > idx + 1) void'(doc_text.pop_back());
                        4:
                        begin
                            doc_text.insert(idx, CH_NUL);
                            repeat ($urandom_range(0, 3))
                                doc_text.push_back(8'($urandom_range(0, 255)));
                        end
                        default:
                            case ($urandom_range(0, 3))
                                0: doc_text.insert(idx, CH_RBRACE);
                                1: doc_text.insert(idx, CH_COMMA);
                                2: doc_text.insert(idx, CH_BSLASH);
                                default: doc_text.insert(idx, CH_TAB);
                            endcase
                    endcase
                end
            end
            emit_text();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every beat taken, every verdict seen, then a short tail
        while (beats_taken < total_beats)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (bad_verdicts == 0 && verdicts_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
